>>> hdl/rlgn_pkg.sv
// shared types and constants for the bit-aligned copy realigner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rlgn_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned AddrW      = 29;
  localparam int unsigned PaddrW     = 4;

  typedef enum logic [1:0] {
    REG_DST_BIT_ADDRESS  = 2'd0,
    REG_SRC_BIT_OFFSET   = 2'd1,
    REG_COPY_LENGTH_BITS = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] dst_bit_address;
    logic [2:0]  src_bit_offset;
    logic [31:0] copy_length_bits;
    logic        restart;
  } cfg_t;

  // one queue entry: up to two destination bytes at consecutive addresses
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [7:0]       data0;
    logic [7:0]       mask0;
    logic             last0;
    logic             two;
    logic [7:0]       data1;
    logic [7:0]       mask1;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/rlgn_regs.sv
// apb register file: destination bit address, source offset, length
// depends on rlgn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlgn_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rlgn_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output rlgn_pkg::cfg_t                  cfg
);

  logic [31:0] dst_r;
  logic [2:0]  src_r;
  logic [31:0] len_r;
  logic        restart_r;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r     <= '0;
      src_r     <= '0;
      len_r     <= '0;
      restart_r <= 1'b0;
    end else begin
      restart_r <= 1'b0;
      if (wr) begin
        unique case (idx)
          rlgn_pkg::REG_DST_BIT_ADDRESS: begin
            dst_r     <= pwdata;
            restart_r <= 1'b1;
          end
          rlgn_pkg::REG_SRC_BIT_OFFSET: begin
            src_r     <= pwdata[2:0];
            restart_r <= 1'b1;
          end
          rlgn_pkg::REG_COPY_LENGTH_BITS: begin
            len_r     <= pwdata;
            restart_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      rlgn_pkg::REG_DST_BIT_ADDRESS:  prdata = dst_r;
      rlgn_pkg::REG_SRC_BIT_OFFSET:   prdata = {29'd0, src_r};
      rlgn_pkg::REG_COPY_LENGTH_BITS: prdata = len_r;
      default:                        prdata = '0;
    endcase
  end

  assign cfg.dst_bit_address  = dst_r;
  assign cfg.src_bit_offset   = src_r;
  assign cfg.copy_length_bits = len_r;
  assign cfg.restart          = restart_r;

endmodule

`default_nettype wire

>>> hdl/rlgn_front.sv
// front end: takes source bytes, packs bits, forms destination byte groups
// depends on rlgn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlgn_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rlgn_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_src_byte,
  output logic                in_stall,
  input  wire logic           q_full,
  output logic                q_push,
  output rlgn_pkg::entry_t    q_entry
);

  logic [14:0]                acc_data_r, acc_data_nxt;
  logic [14:0]                acc_mask_r, acc_mask_nxt;
  logic [3:0]                 acc_fill_r, acc_fill_nxt;
  logic [31:0]                copied_r, copied_nxt;
  logic [rlgn_pkg::AddrW-1:0] addr_r, addr_nxt;

  logic        accept, active, done, emit0, emit1;
  logic [2:0]  start;
  logic [3:0]  take, fill1, fill2;
  logic [31:0] remain;
  logic [8:0]  ones9;
  logic [7:0]  ones, bits;
  logic [14:0] data1, mask1, data2, mask2;

  assign in_stall = q_full | cfg.restart;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    active = copied_r < cfg.copy_length_bits;
    start  = (copied_r == 32'd0) ? cfg.src_bit_offset : 3'd0;
    remain = cfg.copy_length_bits - copied_r;
    take   = 4'd8 - {1'b0, start};
    if (remain < {28'd0, take}) take = remain[3:0];
    ones9  = ~(9'h1FF << take);
    ones   = ones9[7:0];
    bits   = (in_src_byte >> start) & ones;
    data1  = acc_data_r | (15'(bits) << acc_fill_r);
    mask1  = acc_mask_r | (15'(ones) << acc_fill_r);
    fill1  = acc_fill_r + take;
    copied_nxt = copied_r + {28'd0, take};
    done   = copied_nxt == cfg.copy_length_bits;
    emit0  = fill1[3];
    data2  = emit0 ? (data1 >> 8) : data1;
    mask2  = emit0 ? (mask1 >> 8) : mask1;
    fill2  = emit0 ? (fill1 - 4'd8) : fill1;
    emit1  = done & (fill2 != 4'd0);

    q_entry.addr  = addr_r;
    q_entry.data0 = emit0 ? data1[7:0] : data2[7:0];
    q_entry.mask0 = emit0 ? mask1[7:0] : mask2[7:0];
    q_entry.last0 = emit0 ? (done & ~emit1) : 1'b1;
    q_entry.two   = emit0 & emit1;
    q_entry.data1 = data2[7:0];
    q_entry.mask1 = mask2[7:0];

    q_push = accept & active & (emit0 | emit1);

    acc_data_nxt = emit1 ? 15'd0 : data2;
    acc_mask_nxt = emit1 ? 15'd0 : mask2;
    acc_fill_nxt = emit1 ? 4'd0 : fill2;
    addr_nxt     = addr_r + rlgn_pkg::AddrW'({emit0 & emit1, emit0 ^ emit1});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_data_r <= '0;
      acc_mask_r <= '0;
      acc_fill_r <= '0;
      copied_r   <= '0;
      addr_r     <= '0;
    end else if (cfg.restart) begin
      acc_data_r <= '0;
      acc_mask_r <= '0;
      acc_fill_r <= {1'b0, cfg.dst_bit_address[2:0]};
      copied_r   <= '0;
      addr_r     <= cfg.dst_bit_address[31:3];
    end else if (accept && active) begin
      acc_data_r <= acc_data_nxt;
      acc_mask_r <= acc_mask_nxt;
      acc_fill_r <= acc_fill_nxt;
      copied_r   <= copied_nxt;
      addr_r     <= addr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rlgn_queue.sv
// short queue of destination byte groups between front and back
// depends on rlgn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlgn_queue #(
  parameter int unsigned DEPTH = rlgn_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rlgn_pkg::entry_t push_entry,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output rlgn_pkg::entry_t      head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rlgn_pkg::entry_t mem_r [DEPTH];
  logic [PtrW-1:0]  wp_r, rp_r;
  logic [CntW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full      = cnt_r == CntW'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PtrW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PtrW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rlgn_back.sv
// back end: splits byte groups and drives the result output register
// depends on rlgn_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlgn_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_not_empty,
  input  wire rlgn_pkg::entry_t          q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [rlgn_pkg::AddrW-1:0]     out_dst_byte_address,
  output logic [7:0]                     out_data,
  output logic [7:0]                     out_bit_mask,
  output logic                           out_last
);

  logic                       valid_r;
  logic                       phase_r;
  logic [rlgn_pkg::AddrW-1:0] addr_r;
  logic [7:0]                 data_r, mask_r;
  logic                       last_r;
  logic                       open, load;

  assign open  = ~valid_r | ~out_stall;
  assign load  = open & q_not_empty;
  assign q_pop = load & (~q_head.two | phase_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (open) valid_r <= q_not_empty;
      if (load) phase_r <= q_head.two & ~phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (phase_r) begin
        addr_r <= q_head.addr + 1'b1;
        data_r <= q_head.data1;
        mask_r <= q_head.mask1;
        last_r <= 1'b1;
      end else begin
        addr_r <= q_head.addr;
        data_r <= q_head.data0;
        mask_r <= q_head.mask0;
        last_r <= q_head.last0;
      end
    end
  end

  assign out_valid            = valid_r;
  assign out_dst_byte_address = addr_r;
  assign out_data             = data_r;
  assign out_bit_mask         = mask_r;
  assign out_last             = last_r;

endmodule

`default_nettype wire

>>> hdl/bit_aligned_copy_realigner.sv
// bit-aligned copy realigner: one source byte accepted per cycle unless the input stalls; each
// result passes through the byte-group queue and then the output register
// a transfer ending with a full and a partial byte emits two results, one after the other
// input stalls when the byte-group queue is full, and for one cycle after a register write
// synchronous active-low reset clears registers, accumulator and queue; no clearing pass
// depends on rlgn_pkg, rlgn_regs, rlgn_front, rlgn_queue, rlgn_back
`timescale 1ns / 1ps
`default_nettype none

module bit_aligned_copy_realigner #(
  parameter int unsigned QUEUE_DEPTH = rlgn_pkg::QueueDepth
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_src_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rlgn_pkg::AddrW-1:0]       out_dst_byte_address,
  output logic [7:0]                       out_data,
  output logic [7:0]                       out_bit_mask,
  output logic                             out_last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rlgn_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  rlgn_pkg::cfg_t   cfg;
  rlgn_pkg::entry_t push_entry, head;
  logic             push, pop, full, not_empty;

  rlgn_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  rlgn_front u_front (
    .clk, .rst_n, .cfg, .in_valid, .in_src_byte, .in_stall,
    .q_full(full), .q_push(push), .q_entry(push_entry)
  );

  rlgn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_entry, .pop, .full, .not_empty, .head
  );

  rlgn_back u_back (
    .clk, .rst_n, .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
    .out_valid, .out_stall, .out_dst_byte_address, .out_data, .out_bit_mask, .out_last
  );

endmodule

`default_nettype wire

>>> hdl/rlgn_chk.sv
// port-level checker for the realigner, bound to the top level
// depends on rlgn_pkg and bit_aligned_copy_realigner
`timescale 1ns / 1ps
`default_nettype none

module rlgn_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rlgn_pkg::AddrW-1:0]  out_dst_byte_address,
  input wire logic [7:0]                  out_data,
  input wire logic [7:0]                  out_bit_mask,
  input wire logic                        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dst_byte_address)
      && $stable(out_data) && $stable(out_bit_mask) && $stable(out_last))
    else $error("stalled result changed");

  // data bits outside the write mask stay clear
  a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data & ~out_bit_mask) == 8'd0)
    else $error("data outside mask");

  // a byte that is not the last is filled up to its top bit
  a_full_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_bit_mask[7])
    else $error("non-last byte not filled to top");

  a_mask_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bit_mask != 8'd0)
    else $error("empty byte emitted");

endmodule

bind bit_aligned_copy_realigner rlgn_chk u_chk (.*);

`default_nettype wire
